FILE: src/bda_pkg.sv
// ----------------------------------------------------------------------------
// Button debounce package
// Shared sizes, register codes, reset values and lane/merge interface types.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int PIN_W       = 4;
    localparam int MASK_W      = (NUM_BUTTONS < PIN_W) ? NUM_BUTTONS : PIN_W;
    localparam int TIME_W      = 32;
    localparam int DELAY_W     = 16;
    localparam int IDX_W       = 2;
    localparam int CFG_ADDR_W  = 2;

    localparam int S_FIELDS_W  = PIN_W + TIME_W + IDX_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W  = 1 + 1 + PIN_W + PIN_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [DELAY_W-1:0] FIRST_DELAY_RST = 16'd500;
    localparam logic [DELAY_W-1:0] REPEAT_IVL_RST  = 16'd200;
    localparam logic [DELAY_W-1:0] DEBOUNCE_RST    = 16'd50;
    localparam logic               BEEP_EN_RST     = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FIRST_DELAY = 2'd0,
        REG_REPEAT_IVL  = 2'd1,
        REG_DEBOUNCE    = 2'd2,
        REG_BEEP_EN     = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_SCAN = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef struct packed {
        logic [DELAY_W-1:0] first_delay;
        logic [DELAY_W-1:0] repeat_ivl;
        logic [DELAY_W-1:0] debounce;
    } lane_cfg_t;

    typedef struct packed {
        logic latch_cur;
        logic latch_next;
        logic held_next;
    } lane_status_t;

    typedef struct packed {
        logic [PIN_W-1:0] pending_mask;
        logic [PIN_W-1:0] held_mask;
        logic             beep_request;
        logic             read_pressed;
    } result_t;

endpackage

FILE: src/bda_lane.sv
// ----------------------------------------------------------------------------
// Button debounce lane
// One button's mode machine, deadline, held flag and press latch.
// ----------------------------------------------------------------------------
module bda_lane (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  scan_en,
    input  logic                  clear_en,
    input  logic                  pin_high,
    input  logic [31:0]           now_ms,
    input  bda_pkg::lane_cfg_t    cfg,
    output bda_pkg::lane_status_t status
);
    import bda_pkg::*;

    typedef enum logic [1:0] {
        MODE_UNPRESSED = 2'd0,
        MODE_FIRST     = 2'd1,
        MODE_REPEAT    = 2'd2,
        MODE_DEBOUNCE  = 2'd3
    } mode_t;

    mode_t              mode_reg,     mode_next;
    logic               held_reg,     held_next;
    logic               latch_reg,    latch_next;
    logic [TIME_W-1:0]  deadline_reg, deadline_next;
    logic               expired;

    assign expired = (now_ms >= deadline_reg);

    always_comb begin
        mode_next     = mode_reg;
        held_next     = held_reg;
        latch_next    = latch_reg;
        deadline_next = deadline_reg;
        if (scan_en) begin
            if (pin_high) begin
                case (mode_reg)
                    MODE_UNPRESSED: begin
                        mode_next     = MODE_FIRST;
                        held_next     = 1'b1;
                        latch_next    = 1'b1;
                        deadline_next = now_ms + TIME_W'(cfg.first_delay);
                    end
                    MODE_DEBOUNCE: begin
                        // re-press while debouncing: resume repeat, no new report
                        mode_next     = MODE_REPEAT;
                        deadline_next = now_ms + TIME_W'(cfg.repeat_ivl);
                    end
                    default: begin
                        if (expired) begin
                            mode_next     = MODE_REPEAT;
                            latch_next    = 1'b1;
                            deadline_next = now_ms + TIME_W'(cfg.repeat_ivl);
                        end
                    end
                endcase
            end else begin
                case (mode_reg)
                    MODE_FIRST, MODE_REPEAT: begin
                        mode_next     = MODE_DEBOUNCE;
                        deadline_next = now_ms + TIME_W'(cfg.debounce);
                    end
                    MODE_DEBOUNCE: begin
                        if (expired) begin
                            mode_next  = MODE_UNPRESSED;
                            held_next  = 1'b0;
                            latch_next = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (clear_en) begin
            latch_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_UNPRESSED;
            held_reg     <= 1'b0;
            latch_reg    <= 1'b0;
            deadline_reg <= '0;
        end else begin
            mode_reg     <= mode_next;
            held_reg     <= held_next;
            latch_reg    <= latch_next;
            deadline_reg <= deadline_next;
        end
    end

    assign status.latch_cur  = latch_reg;
    assign status.latch_next = latch_next;
    assign status.held_next  = held_next;

endmodule

FILE: src/bda_merge.sv
// ----------------------------------------------------------------------------
// Button debounce merge
// Combine lane status into the read answer and the held/pending masks.
// ----------------------------------------------------------------------------
module bda_merge (
    input  bda_pkg::lane_status_t lane_st [bda_pkg::NUM_BUTTONS],
    input  logic                  is_read,
    input  logic [1:0]            button_index,
    input  logic                  beep_enable,
    output bda_pkg::result_t      result
);
    import bda_pkg::*;

    logic              sel_latch;
    logic [PIN_W-1:0]  held_mask;
    logic [PIN_W-1:0]  pend_mask;

    always_comb begin
        sel_latch = 1'b0;
        // out-of-range index selects nothing and reads zero
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (32'(button_index) == i) begin
                sel_latch = lane_st[i].latch_cur;
            end
        end
    end

    always_comb begin
        held_mask = '0;
        pend_mask = '0;
        for (int i = 0; i < MASK_W; i++) begin
            held_mask[i] = lane_st[i].held_next;
            pend_mask[i] = lane_st[i].latch_next;
        end
    end

    assign result.read_pressed = is_read & sel_latch;
    assign result.beep_request = is_read & sel_latch & beep_enable;
    assign result.held_mask    = held_mask;
    assign result.pending_mask = pend_mask;

endmodule

FILE: src/button_debounce_autorepeat.sv
// ----------------------------------------------------------------------------
// Button debounce with auto-repeat, top level
// Output: m_tvalid rises in the cycle after an input transfer while the output
// register is free; behind a stalled output the result waits in the skid stage.
// Throughput: one item per cycle while m_tready stays high; input is stalled
// while a full skid stage drains. Ready drops only when both stages are full.
// Reset (aresetn low, synchronous): all buttons unpressed, flags clear,
// registers back to 500/200/50 ms and beeps enabled; no result held.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [3:0] pin_levels, [35:4] now_ms, [37:36] button_index, rest zero
    input  logic [bda_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] operation
    input  logic                          s_tuser,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] read_pressed, [1] beep_request, [5:2] held_mask,
    // [9:6] pending_mask, rest zero
    output logic [bda_pkg::M_TDATA_W-1:0] m_tdata,
    // configuration writes
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_addr,
    input  logic [15:0]                   cfg_wdata
);
    import bda_pkg::*;

    // ------------------------------------------------------------------
    // Unpack the input transfer
    // ------------------------------------------------------------------
    logic [PIN_W-1:0]  pin_levels;
    logic [TIME_W-1:0] now_ms;
    logic [IDX_W-1:0]  button_index;
    logic              in_xfer;
    logic              is_read;
    logic              scan_en;

    assign pin_levels   = s_tdata[PIN_W-1:0];
    assign now_ms       = s_tdata[PIN_W+TIME_W-1:PIN_W];
    assign button_index = s_tdata[S_FIELDS_W-1:PIN_W+TIME_W];
    assign in_xfer      = s_tvalid & s_tready;
    assign is_read      = (op_t'(s_tuser) == OP_READ);
    assign scan_en      = in_xfer & ~is_read;

    // ------------------------------------------------------------------
    // Configuration registers, not guarded by the block: the user must write them only while idle
    // ------------------------------------------------------------------
    lane_cfg_t cfg_reg;
    logic      beep_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_delay <= FIRST_DELAY_RST;
            cfg_reg.repeat_ivl  <= REPEAT_IVL_RST;
            cfg_reg.debounce    <= DEBOUNCE_RST;
            beep_en_reg         <= BEEP_EN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_FIRST_DELAY: cfg_reg.first_delay <= cfg_wdata;
                REG_REPEAT_IVL:  cfg_reg.repeat_ivl  <= cfg_wdata;
                REG_DEBOUNCE:    cfg_reg.debounce    <= cfg_wdata;
                REG_BEEP_EN:     beep_en_reg         <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // One lane per button; lanes past the pin count always read released
    // ------------------------------------------------------------------
    lane_status_t lane_st [NUM_BUTTONS];

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        logic pin_high;
        logic clear_en;

        if (g < PIN_W) begin : g_pin
            assign pin_high = pin_levels[g];
        end else begin : g_nopin
            assign pin_high = 1'b0;
        end

        // a read clears only the selected button's latch
        assign clear_en = in_xfer & is_read & (32'(button_index) == g);

        bda_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .scan_en  (scan_en),
            .clear_en (clear_en),
            .pin_high (pin_high),
            .now_ms   (now_ms),
            .cfg      (cfg_reg),
            .status   (lane_st[g])
        );
    end

    // ------------------------------------------------------------------
    // Merge lane status into one result
    // ------------------------------------------------------------------
    result_t result;

    bda_merge u_merge (
        .lane_st      (lane_st),
        .is_read      (is_read),
        .button_index (button_index),
        .beep_enable  (beep_en_reg),
        .result       (result)
    );

    // ------------------------------------------------------------------
    // Output register plus skid stage: take a new item while a finished
    // result waits; hold off input only when both are occupied.
    // ------------------------------------------------------------------
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    out_free;

    assign s_tready = ~skid_valid_reg;
    assign out_free = ~out_valid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                // drain the skid stage first; input is stalled meanwhile
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_xfer;
            end
        end else if (in_xfer) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (in_xfer) begin
                out_reg <= result;
            end
        end else if (in_xfer) begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - M_FIELDS_W)'(0), out_reg};

`ifndef SYNTHESIS
    // the skid stage only fills behind a stalled output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while output register is empty");

    // a beep is only requested for a read that returned a press
    a_beep_needs_press: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (!out_reg.beep_request || out_reg.read_pressed))
        else $error("beep requested without a returned press");

    // a pending press always belongs to a held button
    a_pending_held: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((out_reg.pending_mask & ~out_reg.held_mask) == '0))
        else $error("pending press on a button that is not held");

    // a result appears in the cycle after a transfer into a free output
    a_one_cycle_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && out_free && !skid_valid_reg) |=> out_valid_reg)
        else $error("accepted item did not reach the output register");
`endif

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Button debounce with auto-repeat: self-checking bench
// Drives scan and read transfers into the four-button debouncer, predicts every
// result with a cycle-free model of the per-button machines, and compares each
// result transfer field by field. A short directed table covers reset state,
// first press, repeat timing, re-press during debounce, release clearing and
// deadline wrap near the top of the millisecond counter. Random segments follow
// under several register settings, with and without randomized valid/ready idling.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bda_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int SEG_ITEMS    = 117;
    localparam int HOLD_CYCLES  = 40;
    localparam int MAX_PRINTS   = 50;

    // Per-button debounce machine modes
    typedef enum logic [1:0] {
        BTN_UP     = 2'd0,
        BTN_FIRST  = 2'd1,
        BTN_REPEAT = 2'd2,
        BTN_BOUNCE = 2'd3
    } btn_mode_t;

    // One row of the directed table; want is used only where typed is set
    typedef struct packed {
        op_t               op;
        logic [PIN_W-1:0]  pins;
        logic [TIME_W-1:0] now;
        logic [IDX_W-1:0]  idx;
        logic              typed;
        result_t           want;
    } row_t;

    localparam result_t ALL_CLEAR = '0;

    localparam int N_DIRECTED = 21;
    // Runs under the reset register values: 500 / 200 / 50 ms, beeps on.
    localparam row_t DIRECTED [N_DIRECTED] = '{
        //  op       pins   now            idx   typed  {pend, held, beep, rd}
        // nothing pressed yet: a read returns zero, a released scan is a no-op
        '{OP_READ, 4'h0, 32'd0,          2'd0, 1'b1, ALL_CLEAR},
        '{OP_SCAN, 4'h0, 32'd0,          2'd0, 1'b1, ALL_CLEAR},
        // first press on all four buttons latches every flag
        '{OP_SCAN, 4'hF, 32'd1000,       2'd0, 1'b1, '{4'hF, 4'hF, 1'b0, 1'b0}},
        // destructive read: flag returned once, with a beep
        '{OP_READ, 4'h0, 32'd0,          2'd0, 1'b1, '{4'hE, 4'hF, 1'b1, 1'b1}},
        '{OP_READ, 4'h0, 32'd0,          2'd0, 1'b1, '{4'hE, 4'hF, 1'b0, 1'b0}},
        // one ms short of the first-repeat deadline, then exactly on it
        '{OP_SCAN, 4'hF, 32'd1499,       2'd0, 1'b0, ALL_CLEAR},
        '{OP_SCAN, 4'hF, 32'd1500,       2'd0, 1'b0, ALL_CLEAR},
        '{OP_READ, 4'h0, 32'd0,          2'd3, 1'b0, ALL_CLEAR},
        // release two buttons, then press them again inside debounce
        '{OP_SCAN, 4'h5, 32'd1600,       2'd1, 1'b0, ALL_CLEAR},
        '{OP_SCAN, 4'hF, 32'd1620,       2'd2, 1'b0, ALL_CLEAR},
        // release wins over a repeat deadline that falls due in the same scan
        '{OP_SCAN, 4'h0, 32'd1700,       2'd0, 1'b0, ALL_CLEAR},
        '{OP_SCAN, 4'h0, 32'd1749,       2'd0, 1'b0, ALL_CLEAR},
        '{OP_SCAN, 4'h0, 32'd1750,       2'd0, 1'b1, ALL_CLEAR},
        // press near the top of the counter: the deadline wraps to a small
        // value and the plain compare fires on the very next scan
        '{OP_SCAN, 4'h1, 32'hFFFF_FF00,  2'd0, 1'b1, '{4'h1, 4'h1, 1'b0, 1'b0}},
        '{OP_SCAN, 4'h1, 32'hFFFF_FF01,  2'd0, 1'b0, ALL_CLEAR},
        '{OP_READ, 4'h0, 32'd0,          2'd0, 1'b0, ALL_CLEAR},
        '{OP_SCAN, 4'h1, 32'hFFFF_FFFF,  2'd0, 1'b0, ALL_CLEAR},
        '{OP_READ, 4'h0, 32'd0,          2'd0, 1'b0, ALL_CLEAR},
        '{OP_SCAN, 4'h0, 32'd0,          2'd0, 1'b0, ALL_CLEAR},
        // debounce deadline 50 is long past at the all-ones time
        '{OP_SCAN, 4'h0, 32'hFFFF_FFFF,  2'd0, 1'b1, ALL_CLEAR},
        // read ignores pins and time; nothing latched on button 2
        '{OP_READ, 4'hF, 32'hFFFF_FFFF,  2'd2, 1'b1, ALL_CLEAR}
    };

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [1:0]           cfg_addr  = '0;
    logic [15:0]          cfg_wdata = '0;

    button_debounce_autorepeat u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns period
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the registers and button machines
    // ------------------------------------------------------------------------
    logic [DELAY_W-1:0] cfg_first    = FIRST_DELAY_RST;
    logic [DELAY_W-1:0] cfg_repeat   = REPEAT_IVL_RST;
    logic [DELAY_W-1:0] cfg_debounce = DEBOUNCE_RST;
    logic               cfg_beep     = BEEP_EN_RST;

    btn_mode_t         btn_mode     [NUM_BUTTONS] = '{default: BTN_UP};
    logic              btn_held     [NUM_BUTTONS] = '{default: 1'b0};
    logic              btn_latch    [NUM_BUTTONS] = '{default: 1'b0};
    logic [TIME_W-1:0] btn_deadline [NUM_BUTTONS] = '{default: '0};

    result_t     due_reports [$];   // predicted results, oldest first
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    // Idling knobs, percent of cycles; receiver hold-off request
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          rx_hold_req = 1'b0;
    int unsigned rx_hold_left = 0;

    // Random stimulus state: current pin pattern and millisecond time
    logic [PIN_W-1:0]  pin_state = '0;
    logic [TIME_W-1:0] time_ms   = '0;

    // Advance the button machines by one transfer and return the result.
    function automatic result_t step_buttons(op_t op, logic [PIN_W-1:0] pins,
                                             logic [TIME_W-1:0] now,
                                             logic [IDX_W-1:0] idx);
        result_t r;
        r = '0;
        if (op == OP_SCAN) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                // buttons past the pin field always read released
                if (b < PIN_W && pins[b]) begin
                    case (btn_mode[b])
                        BTN_UP: begin
                            btn_mode[b]     = BTN_FIRST;
                            btn_held[b]     = 1'b1;
                            btn_latch[b]    = 1'b1;
                            btn_deadline[b] = now + TIME_W'(cfg_first);
                        end
                        BTN_BOUNCE: begin
                            // back to repeating without a new press
                            btn_mode[b]     = BTN_REPEAT;
                            btn_deadline[b] = now + TIME_W'(cfg_repeat);
                        end
                        default: begin
                            if (now >= btn_deadline[b]) begin
                                btn_mode[b]     = BTN_REPEAT;
                                btn_deadline[b] = now + TIME_W'(cfg_repeat);
                                btn_latch[b]    = 1'b1;
                            end
                        end
                    endcase
                end else if (btn_mode[b] == BTN_FIRST || btn_mode[b] == BTN_REPEAT) begin
                    btn_mode[b]     = BTN_BOUNCE;
                    btn_deadline[b] = now + TIME_W'(cfg_debounce);
                end else if (btn_mode[b] == BTN_BOUNCE && now >= btn_deadline[b]) begin
                    btn_mode[b]  = BTN_UP;
                    btn_latch[b] = 1'b0;
                    btn_held[b]  = 1'b0;
                end
            end
        end else if (idx < NUM_BUTTONS) begin
            r.read_pressed = btn_latch[idx];
            btn_latch[idx] = 1'b0;
            r.beep_request = r.read_pressed & cfg_beep;
        end
        for (int b = 0; b < MASK_W; b++) begin
            r.held_mask[b]    = btn_held[b];
            r.pending_mask[b] = btn_latch[b];
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h",
                     $realtime, field, got, want);
        mismatches++;
    endtask

    // Offer one transfer, idling first at the sender's rate, and record the
    // predicted result once it is accepted.
    task automatic send_item(op_t op, logic [PIN_W-1:0] pins, logic [TIME_W-1:0] now,
                             logic [IDX_W-1:0] idx, logic typed, result_t want);
        int unsigned gap;
        result_t     predicted;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({idx, now, pins});
        do @(posedge aclk); while (!s_tready);
        // the model still advances on typed rows so later rows stay in step
        predicted = step_buttons(op, pins, now, idx);
        due_reports.push_back(typed ? want : predicted);
    endtask

    // Drop valid and hold until every predicted result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (due_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_reg_t addr, logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (addr)
            REG_FIRST_DELAY: cfg_first    = value;
            REG_REPEAT_IVL:  cfg_repeat   = value;
            REG_DEBOUNCE:    cfg_debounce = value;
            REG_BEEP_EN:     cfg_beep     = value[0];
            default: ;
        endcase
    endtask

    // Write all four registers with the block idle; the unused upper bits of
    // the beep write are random to show they are dropped.
    task automatic apply_settings(logic [15:0] first, logic [15:0] rpt,
                                  logic [15:0] deb, logic beep);
        drain();
        cfg_write(REG_FIRST_DELAY, first);
        cfg_write(REG_REPEAT_IVL,  rpt);
        cfg_write(REG_DEBOUNCE,    deb);
        cfg_write(REG_BEEP_EN,     {15'($urandom_range(32767)), beep});
    endtask

    // Random segment: mostly time-ordered scans with buttons held and released
    // for spans comparable to the programmed delays, reads mixed in, plus some
    // noise (time jumps, near-wrap times, scrambled pins).
    task automatic run_random(int unsigned count, int unsigned hold_at);
        int unsigned max_step;
        int unsigned pick;
        for (int unsigned n = 0; n < count; n++) begin
            max_step = (cfg_first + cfg_repeat + cfg_debounce) / 3 + 3;
            if (n == hold_at) rx_hold_req = 1'b1;
            if ($urandom_range(99) < 30) begin
                send_item(OP_READ, PIN_W'($urandom_range(15)), $urandom(),
                          IDX_W'($urandom_range(3)), 1'b0, ALL_CLEAR);
            end else begin
                pick = $urandom_range(99);
                if (pick < 3) begin
                    time_ms = $urandom();
                end else if (pick < 5) begin
                    time_ms = 32'hFFFF_FFFF - TIME_W'($urandom_range(3 * max_step));
                end else if (pick < 10) begin
                    pin_state = PIN_W'($urandom_range(15));
                end else begin
                    time_ms = time_ms + TIME_W'($urandom_range(max_step));
                    for (int b = 0; b < PIN_W; b++)
                        if ($urandom_range(99) < 15) pin_state[b] = ~pin_state[b];
                end
                send_item(OP_SCAN, pin_state, time_ms, IDX_W'($urandom_range(3)),
                          1'b0, ALL_CLEAR);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random ready, or a long hold-off when requested
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (rx_hold_req) begin
            rx_hold_left = HOLD_CYCLES;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every result transfer against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[M_FIELDS_W-1:0]);
            if (due_reports.size() == 0) begin
                report_mismatch("result with nothing due", m_tdata, 0);
            end else begin
                want = due_reports.pop_front();
                if (got.read_pressed != want.read_pressed)
                    report_mismatch("read_pressed", got.read_pressed, want.read_pressed);
                if (got.beep_request != want.beep_request)
                    report_mismatch("beep_request", got.beep_request, want.beep_request);
                if (got.held_mask != want.held_mask)
                    report_mismatch("held_mask", got.held_mask, want.held_mask);
                if (got.pending_mask != want.pending_mask)
                    report_mismatch("pending_mask", got.pending_mask, want.pending_mask);
                if (m_tdata[M_TDATA_W-1:M_FIELDS_W] != '0)
                    report_mismatch("tdata padding", m_tdata[M_TDATA_W-1:M_FIELDS_W], 0);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL button_debounce_autorepeat");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // sender sparse-idle, receiver heavy-idle
        tx_idle_pct = 23;
        rx_idle_pct = 63;
        for (int i = 0; i < N_DIRECTED; i++)
            send_item(DIRECTED[i].op, DIRECTED[i].pins, DIRECTED[i].now,
                      DIRECTED[i].idx, DIRECTED[i].typed, DIRECTED[i].want);
        run_random(SEG_ITEMS, SEG_ITEMS);

        // all delays zero, beeps off: held scans repeat unless time jumps backwards or the button is leaving debounce
        apply_settings(16'd0, 16'd0, 16'd0, 1'b0);
        run_random(SEG_ITEMS, SEG_ITEMS);

        // swap the idling sides
        tx_idle_pct = 63;
        rx_idle_pct = 23;
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        run_random(SEG_ITEMS, SEG_ITEMS);

        apply_settings(16'($urandom_range(20, 400)), 16'($urandom_range(1, 150)),
                       16'($urandom_range(80)), 1'($urandom_range(1)));
        run_random(SEG_ITEMS, SEG_ITEMS);

        // no idling; hold the receiver off mid-segment so the input stalls
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_settings(FIRST_DELAY_RST, REPEAT_IVL_RST, DEBOUNCE_RST, BEEP_EN_RST);
        run_random(SEG_ITEMS, 30);

        apply_settings(16'($urandom_range(1, 60)), 16'($urandom_range(1, 30)),
                       16'($urandom_range(20)), 1'b1);
        run_random(SEG_ITEMS, SEG_ITEMS);

        drain();
        if (mismatches == 0) begin
            $display("PASS button_debounce_autorepeat");
        end else begin
            $display("FAIL button_debounce_autorepeat");
        end
        $finish;
    end

endmodule
